>>> rtl/tess_pkg.sv
// Package for the two-ended shared stack: operation and status codes,
// the sequencer state type and the underflow word.
// No dependencies.
`timescale 1ns / 1ps

package tess_pkg;

    typedef enum logic [2:0] {
        FUNC_PUSH_A = 3'd0,
        FUNC_PUSH_B = 3'd1,
        FUNC_POP_A  = 3'd2,
        FUNC_POP_B  = 3'd3,
        FUNC_DUMP_A = 3'd4,
        FUNC_DUMP_B = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    localparam logic signed [31:0] UNDERFLOW_WORD = -32'sd999;
    localparam int WORD_W = 32;

endpackage

>>> rtl/tess_ram.sv
// Single-port-write, single-port-read synchronous memory holding both stacks.
// Read data is registered and appears in the cycle after the read request.
// Depends on tess_pkg for the word width.
`timescale 1ns / 1ps

module tess_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                               aclk,
    input  logic                               wr_en,
    input  logic [AW-1:0]                      wr_addr,
    input  logic signed [tess_pkg::WORD_W-1:0] wr_data,
    input  logic                               rd_en,
    input  logic [AW-1:0]                      rd_addr,
    output logic signed [tess_pkg::WORD_W-1:0] rd_data
);
    import tess_pkg::*;

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/two_ended_shared_stack.sv
// Top level of the two-ended shared stack: request decoding, stack counters,
// read sequencer for pops and dumps, and the result register.
// Depends on tess_pkg and tess_ram.
//
//  channel | ports                              | direction | handshake
//  --------+------------------------------------+-----------+-----------------
//  request | s_func, s_push_value               | in        | s_valid/s_ready
//  result  | m_data_word, m_status, m_last      | out       | m_valid/m_ready
//
// A push, an overflow, an underflow or an empty dump is registered at the edge
// that accepts the request; a pop first reads the memory and registers the word
// from the read data in ST_READ. A dump makes one memory read per word, during
// which no request is taken. ST_READ waits while m_ready is low on a held result.
// Reset (synchronous, aresetn low) empties both stacks; no clearing pass.
`timescale 1ns / 1ps

module two_ended_shared_stack #(
    parameter int DEPTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_func,
    input  logic signed [tess_pkg::WORD_W-1:0] s_push_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [tess_pkg::WORD_W-1:0] m_data_word,
    output logic [1:0]                         m_status,
    output logic                               m_last
);
    import tess_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);

    state_t state_reg, state_next;
    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          up_reg, up_next;
    logic          single_reg, single_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [WORD_W-1:0] m_data_reg, m_data_next;
    logic [1:0]               m_status_reg, m_status_next;
    logic                     m_last_reg, m_last_next;

    logic              out_free;
    logic              accept;
    logic              full;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic signed [WORD_W-1:0] rd_data;
    logic              final_word;
    logic [CW:0]       fill_sum;

    tess_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign fill_sum = {1'b0, count_a_reg} + {1'b0, count_b_reg};
    assign full     = fill_sum >= {1'b0, DEPTH_C};
    assign final_word = single_reg || (up_reg ? (ptr_reg == TOP_ADDR) : (ptr_reg == '0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_a_reg <= '0;
            count_b_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg      <= ptr_next;
        up_reg       <= up_next;
        single_reg   <= single_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_a_next  = count_a_reg;
        count_b_next  = count_b_reg;
        ptr_next      = ptr_reg;
        up_next       = up_reg;
        single_next   = single_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        rd_en         = 1'b0;
        rd_addr       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // Every immediate answer is a single result with last set.
                    m_data_next = '0;
                    m_last_next = 1'b1;
                    unique case (s_func)
                        FUNC_PUSH_A, FUNC_PUSH_B: begin
                            m_valid_next = 1'b1;
                            if (full) begin
                                m_status_next = STATUS_OVERFLOW;
                            end else begin
                                m_status_next = STATUS_OK;
                                wr_en = 1'b1;
                                if (s_func == FUNC_PUSH_A) begin
                                    wr_addr      = count_a_reg[AW-1:0];
                                    count_a_next = count_a_reg + 1'b1;
                                end else begin
                                    wr_addr      = AW'(DEPTH_C - count_b_reg - 1'b1);
                                    count_b_next = count_b_reg + 1'b1;
                                end
                            end
                        end
                        FUNC_POP_A, FUNC_DUMP_A: begin
                            if (count_a_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_data_next   = (s_func == FUNC_POP_A) ? UNDERFLOW_WORD : '0;
                                m_status_next = (s_func == FUNC_POP_A) ? STATUS_UNDERFLOW
                                                                       : STATUS_EMPTY;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = AW'(count_a_reg - 1'b1);
                                ptr_next    = rd_addr;
                                up_next     = 1'b0;
                                single_next = (s_func == FUNC_POP_A);
                                state_next  = ST_READ;
                                if (s_func == FUNC_POP_A) begin
                                    count_a_next = count_a_reg - 1'b1;
                                end
                            end
                        end
                        FUNC_POP_B, FUNC_DUMP_B: begin
                            if (count_b_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_data_next   = (s_func == FUNC_POP_B) ? UNDERFLOW_WORD : '0;
                                m_status_next = (s_func == FUNC_POP_B) ? STATUS_UNDERFLOW
                                                                       : STATUS_EMPTY;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = AW'(DEPTH_C - count_b_reg);
                                ptr_next    = rd_addr;
                                up_next     = 1'b1;
                                single_next = (s_func == FUNC_POP_B);
                                state_next  = ST_READ;
                                if (s_func == FUNC_POP_B) begin
                                    count_b_next = count_b_reg - 1'b1;
                                end
                            end
                        end
                        default: begin
                            // Unused codes are taken and dropped without a result.
                        end
                    endcase
                end
            end
            ST_READ: begin
                // The read data register holds its word until the result slot
                // frees, because no new read is issued meanwhile.
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = rd_data;
                    m_status_next = STATUS_OK;
                    m_last_next   = final_word;
                    if (final_word) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next = up_reg ? (ptr_reg + 1'b1) : (ptr_reg - 1'b1);
                        rd_en    = 1'b1;
                        rd_addr  = ptr_next;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_data_word = m_data_reg;
    assign m_status    = m_status_reg;
    assign m_last      = m_last_reg;

endmodule
